// ----- hdl/itra_pkg.sv -----
// Shared types, constants and the control program of the radix text converter.
// Used by every module of the block except the generic RAM.
package itra_pkg;

   // Width of the converted integer and derived widths.
   localparam int VALUE_BITS = 32;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W     = $clog2(VALUE_BITS);
   localparam int BIT_W      = $clog2(VALUE_BITS);
   localparam int RADIX_W    = 6;
   localparam int LEN_W      = 6;
   localparam int CMP_W      = ((CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W) + 1;
   localparam int CHAR_W     = 8;
   localparam int STATUS_W   = 2;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [LEN_W-1:0]   LEN_MIN     = 6'd2;
   localparam logic [LEN_W-1:0]   LEN_RESET   = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RADIX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT_BUF = 2'd2;

   // Configuration register indexes.
   localparam logic REG_RADIX      = 1'b0;
   localparam logic REG_BUFFER_LEN = 1'b1;

   // Datapath actions.
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD       = 4'd1;
   localparam logic [ACT_W-1:0] ACT_DIV_INIT   = 4'd2;
   localparam logic [ACT_W-1:0] ACT_DIV_STEP   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_STORE      = 4'd4;
   localparam logic [ACT_W-1:0] ACT_EMIT_SIGN  = 4'd5;
   localparam logic [ACT_W-1:0] ACT_EMIT_DIGIT = 4'd6;
   localparam logic [ACT_W-1:0] ACT_EMIT_ERR1  = 4'd7;
   localparam logic [ACT_W-1:0] ACT_EMIT_ERR2  = 4'd8;

   // Jump conditions.
   localparam int COND_W = 4;
   localparam logic [COND_W-1:0] COND_NEXT      = 4'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ    = 4'd2;
   localparam logic [COND_W-1:0] COND_SHORT_BUF = 4'd3;
   localparam logic [COND_W-1:0] COND_BAD_RADIX = 4'd4;
   localparam logic [COND_W-1:0] COND_BITS_LEFT = 4'd5;
   localparam logic [COND_W-1:0] COND_MAG_NZ    = 4'd6;
   localparam logic [COND_W-1:0] COND_NO_ROOM   = 4'd7;
   localparam logic [COND_W-1:0] COND_CNT_GT1   = 4'd8;

   // Program addresses.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHK_LEN   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_CHK_RADIX = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIV_INIT  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIV_STEP  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_STORE     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CHK_ROOM  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_SIGN      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_READ      = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DIGIT     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DONE      = 4'd10;
   localparam logic [STEP_W-1:0] STEP_ERR1      = 4'd11;
   localparam logic [STEP_W-1:0] STEP_ERR2      = 4'd12;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic short_buf;
      logic bad_radix;
      logic bits_left;
      logic mag_nz;
      logic no_room;
      logic cnt_gt1;
      logic stall;
   } dp_flags_type;

   // Control store.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:      w = '{ACT_LOAD,       COND_NO_REQ,    STEP_IDLE};
         STEP_CHK_LEN:   w = '{ACT_NONE,       COND_SHORT_BUF, STEP_ERR2};
         STEP_CHK_RADIX: w = '{ACT_NONE,       COND_BAD_RADIX, STEP_ERR1};
         STEP_DIV_INIT:  w = '{ACT_DIV_INIT,   COND_NEXT,      STEP_IDLE};
         STEP_DIV_STEP:  w = '{ACT_DIV_STEP,   COND_BITS_LEFT, STEP_DIV_STEP};
         STEP_STORE:     w = '{ACT_STORE,      COND_MAG_NZ,    STEP_DIV_INIT};
         STEP_CHK_ROOM:  w = '{ACT_NONE,       COND_NO_ROOM,   STEP_ERR2};
         STEP_SIGN:      w = '{ACT_EMIT_SIGN,  COND_NEXT,      STEP_IDLE};
         STEP_READ:      w = '{ACT_NONE,       COND_NEXT,      STEP_IDLE};
         STEP_DIGIT:     w = '{ACT_EMIT_DIGIT, COND_CNT_GT1,   STEP_READ};
         STEP_DONE:      w = '{ACT_NONE,       COND_ALWAYS,    STEP_IDLE};
         STEP_ERR1:      w = '{ACT_EMIT_ERR1,  COND_ALWAYS,    STEP_IDLE};
         STEP_ERR2:      w = '{ACT_EMIT_ERR2,  COND_ALWAYS,    STEP_IDLE};
         default:        w = '{ACT_NONE,       COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

   // Digit value to its lower-case ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 6'd10) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else if (d < RADIX_MAX) begin
         c = CHAR_A + CHAR_W'(d - 6'd10);
      end else begin
         c = CHAR_ZERO;
      end
      return c;
   endfunction

endpackage

// ----- hdl/itra_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module itra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/itra_sequencer.sv -----
// Microcode sequencer: step counter, control store and jump logic.
// Depends on itra_pkg for the program, codes and the flag/control types.
module itra_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  itra_pkg::dp_flags_type flags,
   output itra_pkg::ctrl_word_type ctrl,
   output logic                   go
);
   import itra_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type     word;
   logic              hit;

   assign word = ucode_rom(step_ff);
   assign go   = !flags.stall;

   always_comb begin
      unique case (word.cond)
         COND_NEXT:      hit = 1'b0;
         COND_ALWAYS:    hit = 1'b1;
         COND_NO_REQ:    hit = !flags.req_valid;
         COND_SHORT_BUF: hit = flags.short_buf;
         COND_BAD_RADIX: hit = flags.bad_radix;
         COND_BITS_LEFT: hit = flags.bits_left;
         COND_MAG_NZ:    hit = flags.mag_nz;
         COND_NO_ROOM:   hit = flags.no_room;
         COND_CNT_GT1:   hit = flags.cnt_gt1;
         default:        hit = 1'b1;
      endcase
   end

   always_comb begin
      if (!go) begin
         step_in = step_ff;
      end else if (hit) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = word;

endmodule

// ----- hdl/itra_datapath.sv -----
// Datapath: magnitude and remainder registers, bit-serial divider, digit store,
// and the result register. Depends on itra_pkg and itra_ram.
module itra_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  itra_pkg::ctrl_word_type             ctrl,
   input  logic                                go,
   input  logic [itra_pkg::RADIX_W-1:0]        radix,
   input  logic [itra_pkg::LEN_W-1:0]          buffer_len,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [itra_pkg::VALUE_BITS-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itra_pkg::CHAR_W-1:0]         rsp_tdata,
   output logic                                rsp_tlast,
   output logic [itra_pkg::STATUS_W-1:0]       rsp_tuser,
   output itra_pkg::dp_flags_type              flags
);
   import itra_pkg::*;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [BIT_W-1:0]      bitcnt_ff, bitcnt_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;

   logic [VALUE_BITS-1:0] abs_value;
   logic [RADIX_W:0]      shifted;
   logic [RADIX_W:0]      diff;
   logic                  qbit;
   logic [CNT_W-1:0]      cnt_dec;
   logic [CMP_W-1:0]      chars_needed;
   logic                  emitting;
   logic                  load_out;
   logic                  ram_wr_en;
   logic [RADIX_W-1:0]    ram_rd_data;

   assign abs_value = req_tdata[VALUE_BITS-1] ? (~req_tdata + VALUE_BITS'(1)) : req_tdata;

   // One restoring division step: remainder gains the next dividend bit.
   assign shifted = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, radix};
   assign qbit    = (shifted >= {1'b0, radix});

   assign cnt_dec      = count_ff - CNT_W'(1);
   assign chars_needed = CMP_W'(count_ff) + CMP_W'(neg_ff) + CMP_W'(1);

   always_comb begin
      unique case (ctrl.act)
         ACT_EMIT_SIGN:  emitting = neg_ff;
         ACT_EMIT_DIGIT: emitting = 1'b1;
         ACT_EMIT_ERR1:  emitting = 1'b1;
         ACT_EMIT_ERR2:  emitting = 1'b1;
         default:        emitting = 1'b0;
      endcase
   end

   assign req_tready = (ctrl.act == ACT_LOAD) && !reset;
   assign load_out   = go && emitting;
   assign ram_wr_en  = go && (ctrl.act == ACT_STORE);

   always_comb begin
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      bitcnt_in     = bitcnt_ff;
      count_in      = count_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (go) begin
         unique case (ctrl.act)
            ACT_LOAD: begin
               if (req_tvalid) begin
                  mag_in   = abs_value;
                  neg_in   = req_tdata[VALUE_BITS-1];
                  count_in = '0;
               end
            end
            ACT_DIV_INIT: begin
               rem_in    = '0;
               bitcnt_in = BIT_W'(VALUE_BITS - 1);
            end
            ACT_DIV_STEP: begin
               rem_in    = qbit ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
               mag_in    = {mag_ff[VALUE_BITS-2:0], qbit};
               bitcnt_in = bitcnt_ff - BIT_W'(1);
            end
            ACT_STORE: begin
               count_in = count_ff + CNT_W'(1);
            end
            ACT_EMIT_SIGN: begin
               // A positive value leaves the result register alone.
               if (neg_ff) begin
                  out_char_in   = CHAR_MINUS;
                  out_last_in   = 1'b0;
                  out_status_in = STATUS_OK;
               end
            end
            ACT_EMIT_DIGIT: begin
               out_char_in   = digit_char(ram_rd_data);
               out_last_in   = (count_ff == CNT_W'(1));
               out_status_in = STATUS_OK;
               count_in      = cnt_dec;
            end
            ACT_EMIT_ERR1: begin
               out_char_in   = CHAR_NUL;
               out_last_in   = 1'b1;
               out_status_in = STATUS_BAD_RADIX;
            end
            ACT_EMIT_ERR2: begin
               out_char_in   = CHAR_NUL;
               out_last_in   = 1'b1;
               out_status_in = STATUS_SHORT_BUF;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         bitcnt_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         bitcnt_ff    <= bitcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      out_char_ff   <= out_char_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   // Digits are written least significant first and read back in reverse.
   itra_ram #(
      .WIDTH (RADIX_W),
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (rem_ff),
      .rd_addr (cnt_dec[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign flags.req_valid = req_tvalid;
   assign flags.short_buf = (buffer_len < LEN_MIN);
   assign flags.bad_radix = (radix < RADIX_MIN) || (radix > RADIX_MAX);
   assign flags.bits_left = (bitcnt_ff != '0);
   assign flags.mag_nz    = (mag_ff != '0);
   assign flags.no_room   = (chars_needed > CMP_W'(buffer_len));
   assign flags.cnt_gt1   = (count_ff > CNT_W'(1));
   assign flags.stall     = emitting && out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- hdl/int_to_radix_ascii.sv -----
// Signed integer to ASCII text converter, top level with configuration registers.
// Depends on itra_pkg, itra_sequencer, itra_datapath and itra_ram.
//
// Usage:
// The req stream carries one signed 32-bit integer per transaction. The rsp
// stream returns its text in the configured radix, one character per
// transaction, most significant first, with a leading '-' for negative values;
// tlast marks the final character. tuser carries the status: 0 ok, 1 radix out
// of range, 2 buffer too short. An error yields a single transaction with
// character 0 and tlast set.
// Registers: radix at address 0 (reset 10), buffer_len at address 4 (reset 10,
// length including the unsent terminator). Write them only while idle.
// Timing: the divider produces one quotient bit per cycle; each digit takes an
// init step, one shift-subtract step per value bit and a store step. One input
// is in work at a time: the next transaction is accepted only after the last
// character of the previous one has been emitted.
// Reset returns the sequencer to idle, empties the result register and
// restores the register defaults. When the receiver stalls, the sequencer
// holds at the next emit step and resumes when the result register is taken.
module int_to_radix_ascii (
   input  logic                            clock,
   input  logic                            reset,
   // APB-style configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   // Input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [itra_pkg::VALUE_BITS-1:0] req_tdata,   // [31:0] value
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itra_pkg::CHAR_W-1:0]     rsp_tdata,   // [7:0] char_code
   output logic                            rsp_tlast,
   output logic [itra_pkg::STATUS_W-1:0]   rsp_tuser    // [1:0] status
);
   import itra_pkg::*;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [LEN_W-1:0]   buffer_len_ff, buffer_len_in;
   logic               csr_write;
   logic               reg_sel;
   ctrl_word_type      ctrl;
   dp_flags_type       flags;
   logic               go;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      radix_in      = radix_ff;
      buffer_len_in = buffer_len_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_RADIX:      radix_in      = csr_pwdata[RADIX_W-1:0];
            REG_BUFFER_LEN: buffer_len_in = csr_pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         buffer_len_ff <= LEN_RESET;
      end else begin
         radix_ff      <= radix_in;
         buffer_len_ff <= buffer_len_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RADIX:      csr_prdata = 32'(radix_ff);
         REG_BUFFER_LEN: csr_prdata = 32'(buffer_len_ff);
         default:        csr_prdata = '0;
      endcase
   end

   itra_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .go    (go)
   );

   itra_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .go         (go),
      .radix      (radix_ff),
      .buffer_len (buffer_len_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .flags      (flags)
   );

endmodule
